// ===== src/pma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path moving average package
// Shared widths, reset values and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pma_pkg;

    // Field widths of the point and result items.
    localparam int COORD_W = 32;
    localparam int STAMP_W = 32;

    // Window length register.
    localparam int WIN_LEN_W = 7;
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 7'd8;

    // Default depth of the point history.
    localparam int MAX_WINDOW_DEF = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // Latch an accepted request.
        logic prepare;   // Apply new-path clearing, wrap index, read oldest slot.
        logic update;    // Update sums, write history, start both dividers.
        logic out_load;  // Move both quotients into the output register.
    } pma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;  // Both dividers hold a finished quotient.
        logic out_free;  // The output register can take a new result.
    } pma_status_t;

endpackage

// ===== src/path_moving_average_2d_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-dimensional path moving average
// Mean of the most recent window_len points per coordinate, Q16.16, with
// the timestamp of each point passed through.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  -------  --------------------  -------------------------------
//  in       in_valid / in_stall   start_path, pos_x, pos_y, stamp
//  out      out_valid / out_stall avg_x, avg_y, stamp_out
//  cfg      cfg_we                cfg_wdata (window_len)
//
//  Each request passes through capture, history read and sum update, then the
//  two serial dividers, one quotient bit per cycle, before its result is
//  loaded into the output register.
//  A new request is taken while the previous result waits in the output
//  register; a stalled output only holds the block once the next result is due.
//  Reset clears the sums, the fill count, the ring index and sets window_len
//  to 8; the history memory needs no clearing.
// ----------------------------------------------------------------------------
module path_moving_average_2d_top #(
    parameter int MAX_WINDOW = pma_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pma_pkg::WIN_LEN_W-1:0]       cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_path,
    input  logic signed [pma_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [pma_pkg::COORD_W-1:0]  pos_y,
    input  logic [pma_pkg::STAMP_W-1:0]         stamp,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pma_pkg::COORD_W-1:0]  avg_x,
    output logic signed [pma_pkg::COORD_W-1:0]  avg_y,
    output logic [pma_pkg::STAMP_W-1:0]         stamp_out
);

    import pma_pkg::*;

    pma_cmd_t    cmd;
    pma_status_t status;

    // Sequencer.
    pma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // History, sums, dividers and output register.
    pma_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start_path (start_path),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .stamp      (stamp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .avg_x      (avg_x),
        .avg_y      (avg_y),
        .stamp_out  (stamp_out)
    );

endmodule

// ===== src/pma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of a signed dividend by a positive divisor, one quotient
// bit per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pma_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 7,
    parameter int QUO_W = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic                    done,
    output logic [QUO_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] shift_reg;
    logic [DVD_W-1:0] shift_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVD_W-1:0] mag_in;
    logic [DVD_W-1:0] signed_quo;

    // Magnitude of the dividend; the most negative value maps to itself as unsigned.
    assign mag_in = dividend[DVD_W-1] ? (~dividend + DVD_W'(1)) : dividend;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign trial = {rem_reg, shift_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            shift_next = mag_in;
            rem_next   = '0;
            cnt_next   = CNT_W'(DVD_W);
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[DVD_W-2:0], fits};
            rem_next   = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
            neg_reg <= dividend[DVD_W-1];
        end
    end

    // Restore the sign of the quotient.
    assign signed_quo = neg_reg ? (~shift_reg + DVD_W'(1)) : shift_reg;
    assign quotient   = signed_quo[QUO_W-1:0];
    assign done       = done_reg;

endmodule

// ===== src/pma_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path moving average controller
// Sequences one request through capture, history read, sum update, division
// and result hand-off.
// ----------------------------------------------------------------------------
module pma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pma_pkg::pma_status_t status,
    output pma_pkg::pma_cmd_t    cmd
);

    import pma_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_WAIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.prepare = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.div_done && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== src/pma_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path moving average datapath
// Point history memory, running sums, fill count and ring index, two serial
// dividers and the output register.
// ----------------------------------------------------------------------------
module pma_datapath #(
    parameter int MAX_WINDOW = pma_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pma_pkg::pma_cmd_t                   cmd,
    output pma_pkg::pma_status_t                status,
    input  logic                                cfg_we,
    input  logic [pma_pkg::WIN_LEN_W-1:0]       cfg_wdata,
    input  logic                                start_path,
    input  logic signed [pma_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [pma_pkg::COORD_W-1:0]  pos_y,
    input  logic [pma_pkg::STAMP_W-1:0]         stamp,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pma_pkg::COORD_W-1:0]  avg_x,
    output logic signed [pma_pkg::COORD_W-1:0]  avg_y,
    output logic [pma_pkg::STAMP_W-1:0]         stamp_out
);

    import pma_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = COORD_W + IDX_W;

    // Window length register and its clamped value.
    logic [WIN_LEN_W-1:0] win_len_reg;
    logic [CNT_W-1:0]     win_eff;

    always_comb
    begin
        priority if (win_len_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (32'(win_len_reg) > 32'(MAX_WINDOW))
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_W'(win_len_reg);
        end
    end

    // Captured request.
    logic                      start_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [STAMP_W-1:0]        stamp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            start_reg <= start_path;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            stamp_reg <= stamp;
        end
    end

    // Path state.
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic signed [SUM_W-1:0] sum_y_next;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [IDX_W-1:0]        idx_prep;
    logic [CNT_W-1:0]        idx_inc;
    logic                    full;
    logic [2*COORD_W-1:0]    hist_rdata;
    logic signed [SUM_W-1:0] old_x;
    logic signed [SUM_W-1:0] old_y;

    // A new path restarts at slot zero; a slot past the window wraps to zero.
    assign idx_prep = (start_reg || (CNT_W'(idx_reg) >= win_eff)) ? '0 : idx_reg;
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign full     = (fill_reg == win_eff);
    assign old_x    = SUM_W'(signed'(hist_rdata[2*COORD_W-1:COORD_W]));
    assign old_y    = SUM_W'(signed'(hist_rdata[COORD_W-1:0]));

    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        if (cmd.prepare)
        begin
            idx_next = idx_prep;
            if (start_reg)
            begin
                sum_x_next = '0;
                sum_y_next = '0;
                fill_next  = '0;
            end
        end
        else if (cmd.update)
        begin
            // Add the new point and drop the oldest once the window is full.
            sum_x_next = sum_x_reg + SUM_W'(x_reg) - (full ? old_x : SUM_W'(0));
            sum_y_next = sum_y_reg + SUM_W'(y_reg) - (full ? old_y : SUM_W'(0));
            fill_next  = full ? fill_reg : fill_reg + CNT_W'(1);
            idx_next   = (idx_inc >= win_eff) ? '0 : IDX_W'(idx_inc);
        end
    end

    // A register write also starts a new path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WIN_LEN_RST;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
        end
        else if (cfg_we)
        begin
            win_len_reg <= cfg_wdata;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

    // Point history: x in the upper half of each word, y in the lower half.
    logic [2*COORD_W-1:0] hist_mem [MAX_WINDOW];

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hist_mem[idx_reg] <= {x_reg, y_reg};
        end
        if (cmd.prepare)
        begin
            hist_rdata <= hist_mem[idx_prep];
        end
    end

    // One divider per coordinate, both started with the updated sums.
    logic               done_x;
    logic               done_y;
    logic [COORD_W-1:0] quo_x;
    logic [COORD_W-1:0] quo_y;

    pma_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .QUO_W (COORD_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update),
        .dividend (sum_x_next),
        .divisor  (fill_next),
        .done     (done_x),
        .quotient (quo_x)
    );

    pma_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .QUO_W (COORD_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update),
        .dividend (sum_y_next),
        .divisor  (fill_next),
        .done     (done_y),
        .quotient (quo_y)
    );

    // Output register.
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            avg_x     <= quo_x;
            avg_y     <= quo_y;
            stamp_out <= stamp_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.div_done = done_x && done_y;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule
